### rtl/dcpd_pkg.sv
// Shared constants, register indexes and beat types for the DC-blocked peak detector.
package dcpd_pkg;

  localparam int MAX_PEAKS   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int KEY_BITS    = 32;

  localparam int ACC_W      = 32;
  localparam int DIFF_W     = 33;
  localparam int COEFF_W    = 16;
  localparam int THR_W      = 32;
  localparam int PCNT_W     = 4;
  localparam int RANK_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // count of beats still to send (holds MAX_PEAKS itself), and rank index
  localparam int CNT_W = $clog2(MAX_PEAKS + 1);
  localparam int IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_COUNT     = 2'd2;

  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd62259;
  localparam logic [THR_W-1:0]   THR_RST   = 32'd0;
  localparam logic [PCNT_W-1:0]  PCNT_RST  = 4'd8;

  typedef struct packed {
    logic                          vld;
    logic [KEY_BITS-1:0]           key;
    logic signed [SAMPLE_BITS-1:0] value;
  } entry_t;

  // one operation on the ranked list: clear, insert one peak, snapshot and clear
  typedef struct packed {
    logic   clr;
    logic   emit;
    entry_t ins;
  } list_op_t;

  typedef struct packed {
    logic                          first;
    logic                          last;
    logic [KEY_BITS-1:0]           key;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [ACC_W-1:0]       acc_new;
    logic signed [ACC_W-1:0]       acc_old;
  } s1_t;

endpackage

### rtl/dcpd_filter.sv
// Recursive filter stage: acc = x + round(a * acc), saturated to 32 bits.
module dcpd_filter
  import dcpd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [KEY_BITS-1:0]           key,
  input  logic                          first,
  input  logic                          last,
  input  logic [COEFF_W-1:0]            coeff,
  output s1_t                           s1_r
);

  localparam int PROD_W = ACC_W + COEFF_W + 1;
  localparam int RND_W  = PROD_W - COEFF_W;
  localparam int SUM_W  = ACC_W + 2;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_old;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat;
  s1_t                      s1_nxt;

  always_comb begin
    acc_old  = first ? ACC_W'(x) : acc_r;
    prod     = PROD_W'(acc_old) * $signed({1'b0, coeff});
    // half rounds up; upper bits of the sum are the floor
    prod_rnd = prod + PROD_W'(32'sd32768);
    rnd      = prod_rnd[PROD_W-1:COEFF_W];
    sum      = SUM_W'(x) + SUM_W'(rnd);
    sat      = (sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b0}}) &&
               (sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b1}});
    acc_nxt  = sat ? {sum[SUM_W-1], {(ACC_W-1){~sum[SUM_W-1]}}} : sum[ACC_W-1:0];

    s1_nxt.first   = first;
    s1_nxt.last    = last;
    s1_nxt.key     = key;
    s1_nxt.x       = x;
    s1_nxt.acc_new = acc_nxt;
    s1_nxt.acc_old = acc_old;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### rtl/dcpd_region.sv
// Crossing detector and open-region tracker; issues list operations.
module dcpd_region
  import dcpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  s1_t                     s1,
  input  logic signed [THR_W-1:0] thr,
  input  logic                    op_ready,
  output logic                    s1_take,
  output logic                    op_valid_r,
  output list_op_t                op_r
);

  logic signed [DIFF_W-1:0]      prev_diff_r;
  logic                          region_open_r;
  logic [KEY_BITS-1:0]           open_key_r;
  logic signed [SAMPLE_BITS-1:0] open_value_r;
  logic                          pend_r;
  entry_t                        pend_ins_r;

  logic signed [ACC_W-1:0]       acc_new;
  logic signed [ACC_W-1:0]       acc_old;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [DIFF_W-1:0]      prev;
  logic signed [DIFF_W-1:0]      thr_x;
  logic                          ro;
  logic                          ro2;
  logic                          rise;
  logic                          fall;
  logic [KEY_BITS-1:0]           ok;
  logic signed [SAMPLE_BITS-1:0] ov;
  entry_t                        ins_a;
  entry_t                        fin;
  logic                          dbl;
  list_op_t                      new_op;
  list_op_t                      pend_op;

  assign s1_take = op_ready && !pend_r && s1_valid;

  always_comb begin
    acc_new = s1.acc_new;
    acc_old = s1.acc_old;
    x       = s1.x;
    diff    = DIFF_W'(acc_new) - DIFF_W'(acc_old);
    prev    = s1.first ? DIFF_W'(x) : prev_diff_r;
    thr_x   = DIFF_W'(thr);
    ro      = s1.first ? 1'b0 : region_open_r;
    rise    = (prev < thr_x) && (diff > thr_x);
    fall    = (prev > thr_x) && (diff < thr_x);

    ins_a.vld   = (rise || fall) && ro;
    ins_a.key   = open_key_r;
    ins_a.value = open_value_r;

    ro2 = ro;
    ok  = open_key_r;
    ov  = open_value_r;
    if (rise) begin
      ro2 = 1'b1;
      ok  = s1.key;
      ov  = x;
    end else if (fall) begin
      ro2 = 1'b0;
    end
    if (ro2 && (ov < x)) begin
      ok = s1.key;
      ov = x;
    end

    // region still open at frame end
    fin.vld   = s1.last && ro2;
    fin.key   = ok;
    fin.value = ov;

    dbl        = ins_a.vld && fin.vld;
    new_op.clr  = s1.first;
    new_op.emit = s1.last && !dbl;
    new_op.ins  = ins_a.vld ? ins_a : fin;

    pend_op.clr  = 1'b0;
    pend_op.emit = 1'b1;
    pend_op.ins  = pend_ins_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_diff_r   <= '0;
      region_open_r <= 1'b0;
      open_key_r    <= '0;
      open_value_r  <= '0;
      pend_r        <= 1'b0;
      op_valid_r    <= 1'b0;
    end else begin
      if (s1_take) begin
        prev_diff_r   <= diff;
        region_open_r <= ro2 && !s1.last;
        open_key_r    <= ok;
        open_value_r  <= ov;
      end
      if (op_ready) begin
        op_valid_r <= pend_r || s1_valid;
        pend_r     <= pend_r ? 1'b0 : (s1_valid && dbl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && (pend_r || s1_valid)) begin
      op_r <= pend_r ? pend_op : new_op;
    end
    if (s1_take) begin
      pend_ins_r <= fin;
    end
  end

endmodule

### rtl/dcpd_rank_cell.sv
// One slot of the ranked peak list; shifts toward its right neighbor on insert.
module dcpd_rank_cell
  import dcpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  list_op_t op,
  input  entry_t   left,
  input  logic     left_beat,
  output entry_t   own,
  output logic     beat,
  output entry_t   nxt
);

  logic                          vld_r;
  logic [KEY_BITS-1:0]           key_r;
  logic signed [SAMPLE_BITS-1:0] value_r;
  logic signed [SAMPLE_BITS-1:0] ins_value;

  always_comb begin
    own.vld   = vld_r && !op.clr;
    own.key   = key_r;
    own.value = value_r;
    ins_value = op.ins.value;
    // a tie keeps the earlier peak here
    beat      = op.ins.vld && (!own.vld || (value_r < ins_value));
    if (left_beat) begin
      nxt = left;
    end else if (beat) begin
      nxt = op.ins;
    end else begin
      nxt = own;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (go) begin
      vld_r <= op.emit ? 1'b0 : nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      key_r   <= nxt.key;
      value_r <= nxt.value;
    end
  end

endmodule

### rtl/dc_blocked_peak_detect_topk.sv
// Top level of the DC-blocked threshold peak detector with a ranked top-K list.
//
// Input beats carry one sample, its key and frame marks (in_valid / in_stall).
// in_first_of_frame seeds the filter with the sample and clears the list;
// in_last_of_frame closes the frame and starts a burst of ranked result beats
// on the out_ channel, one per rank, out_last_result on the final one.
// Config is written through cfg_we / cfg_index / cfg_data while idle.
//
// Throughput: one sample per cycle while no stall holds it; a frame end that
// inserts both a closed peak and the still-open one issues two list operations
// and holds the input during the second. The filter recursion (one 32x17
// multiply, round, add, saturate) is combinational around its accumulator;
// the sorted insert is a row of cells that all compare against the new peak
// at once and shift right. A last sample passes the filter, list operation
// and snapshot registers before its first result beat, plus a second list
// operation when both peaks go in. The burst of peak_count beats is drained
// from a snapshot row, so the next frame keeps flowing; only a further frame
// end waits for the snapshot to empty, and that wait stalls the input.
// Reset (rst_n low, synchronous) empties the pipeline, the list and the
// snapshot, zeroes the filter and loads the config defaults. A stalled
// result beat holds; back-pressure reaches in_stall through the pipe.
module dc_blocked_peak_detect_topk
  import dcpd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [KEY_BITS-1:0]           in_sample_key,
  input  logic                          in_first_of_frame,
  input  logic                          in_last_of_frame,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_peak_found,
  output logic [KEY_BITS-1:0]           out_peak_key,
  output logic signed [SAMPLE_BITS-1:0] out_peak_value,
  output logic [RANK_W-1:0]             out_peak_rank,
  output logic                          out_last_result,

  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // config registers
  logic [COEFF_W-1:0]      coeff_r;
  logic signed [THR_W-1:0] thr_r;
  logic [PCNT_W-1:0]       pcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= COEFF_RST;
      thr_r   <= THR_RST;
      pcnt_r  <= PCNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_COEFF:   coeff_r <= cfg_data[COEFF_W-1:0];
        CFG_PEAK_THRESHOLD: thr_r   <= cfg_data[THR_W-1:0];
        CFG_PEAK_COUNT:     pcnt_r  <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: filter
  logic in_acc;
  logic s1_valid_r;
  logic s1_take;
  s1_t  s1;

  assign in_stall = s1_valid_r && !s1_take;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  dcpd_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .x     (in_sample_value),
    .key   (in_sample_key),
    .first (in_first_of_frame),
    .last  (in_last_of_frame),
    .coeff (coeff_r),
    .s1_r  (s1)
  );

  // stage 2: crossings and region tracking
  logic     op_valid_r;
  list_op_t op_r;
  logic     op_ready;
  logic     list_go;

  dcpd_region u_region (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1         (s1),
    .thr        (thr_r),
    .op_ready   (op_ready),
    .s1_take    (s1_take),
    .op_valid_r (op_valid_r),
    .op_r       (op_r)
  );

  // stage 3: ranked list, one cell per rank
  logic   [CNT_W-1:0] cnt_r;
  logic   [IDX_W-1:0] idx_r;
  logic               out_acc;
  logic               out_free;
  logic   [CNT_W-1:0] n_emit;
  entry_t             cell_own  [MAX_PEAKS];
  logic               cell_beat [MAX_PEAKS];
  entry_t             cell_nxt  [MAX_PEAKS];
  entry_t             snap_r    [MAX_PEAKS];

  assign out_acc  = out_valid && !out_stall;
  // snapshot row is free now or frees on this beat
  assign out_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_acc);
  assign list_go  = op_valid_r && (!op_r.emit || out_free);
  assign op_ready = !op_valid_r || list_go;

  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
    entry_t left;
    logic   left_beat;
    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_beat = 1'b0;
    end else begin : g_link
      assign left      = cell_own[i-1];
      assign left_beat = cell_beat[i-1];
    end

    dcpd_rank_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .go        (list_go),
      .op        (op_r),
      .left      (left),
      .left_beat (left_beat),
      .own       (cell_own[i]),
      .beat      (cell_beat[i]),
      .nxt       (cell_nxt[i])
    );
  end

  // result snapshot: empty ranks read as zero, shifts toward rank 0 per beat
  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_snap
    entry_t load_val;
    entry_t shift_val;
    assign load_val.vld   = cell_nxt[i].vld;
    assign load_val.key   = cell_nxt[i].vld ? cell_nxt[i].key : '0;
    assign load_val.value = cell_nxt[i].vld ? cell_nxt[i].value : '0;
    if (i == MAX_PEAKS - 1) begin : g_tail
      assign shift_val = '0;
    end else begin : g_mid
      assign shift_val = snap_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (list_go && op_r.emit) begin
        snap_r[i] <= load_val;
      end else if (out_acc) begin
        snap_r[i] <= shift_val;
      end
    end
  end

  // ranks to report: zero counts as one, clipped to the list depth
  always_comb begin
    if (pcnt_r == '0) begin
      n_emit = CNT_W'(1);
    end else if (32'(pcnt_r) > MAX_PEAKS) begin
      n_emit = CNT_W'(MAX_PEAKS);
    end else begin
      n_emit = CNT_W'(pcnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (list_go && op_r.emit) begin
      cnt_r <= n_emit;
      idx_r <= '0;
    end else if (out_acc) begin
      cnt_r <= cnt_r - CNT_W'(1);
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_peak_found  = snap_r[0].vld;
  assign out_peak_key    = snap_r[0].key;
  assign out_peak_value  = snap_r[0].value;
  assign out_peak_rank   = RANK_W'(idx_r);
  assign out_last_result = (cnt_r == CNT_W'(1));

endmodule

### bench/dcpd_rank_checker.sv
// Scoreboard for the peak detector: tracks the filter and ranked list, checks each rank beat.
`timescale 1ns / 1ps
module dcpd_rank_checker
  import dcpd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [KEY_BITS-1:0]           in_sample_key,
  input  logic                          in_first_of_frame,
  input  logic                          in_last_of_frame,

  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_peak_found,
  input  logic [KEY_BITS-1:0]           out_peak_key,
  input  logic signed [SAMPLE_BITS-1:0] out_peak_value,
  input  logic [RANK_W-1:0]             out_peak_rank,
  input  logic                          out_last_result,

  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,

  output int                            mismatch_count,
  output int                            beats_pending
);

  localparam int     REPORT_MAX = 10;
  localparam longint ACC_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ACC_MIN    = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic                          found;
    logic [KEY_BITS-1:0]           key;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [RANK_W-1:0]             rank;
    logic                          last;
  } rank_beat_t;

  rank_beat_t ranks_due[$];
  int         bad_beats = 0;

  // register copies
  logic [COEFF_W-1:0]            coeff;
  logic signed [THR_W-1:0]       thr;
  logic [PCNT_W-1:0]             pcnt;

  // detector state
  logic signed [ACC_W-1:0]       acc;
  logic signed [DIFF_W-1:0]      last_step;
  logic                          region_live;
  logic [KEY_BITS-1:0]           live_key;
  logic signed [SAMPLE_BITS-1:0] live_value;
  entry_t                        board [MAX_PEAKS];

  function automatic void clear_board();
    int i;
    for (i = 0; i < MAX_PEAKS; i++) board[i] = '0;
  endfunction

  function automatic void reset_detector();
    coeff       = COEFF_RST;
    thr         = THR_RST;
    pcnt        = PCNT_RST;
    acc         = '0;
    last_step   = '0;
    region_live = 1'b0;
    live_key    = '0;
    live_value  = '0;
    clear_board();
  endfunction

  // sorted insert, ties keep the older entry ahead
  function automatic void rank_insert(logic [KEY_BITS-1:0] k, logic signed [SAMPLE_BITS-1:0] v);
    int pos;
    int i;
    pos = 0;
    while (pos < MAX_PEAKS && board[pos].vld && $signed(board[pos].value) >= v) pos++;
    if (pos < MAX_PEAKS) begin
      for (i = MAX_PEAKS - 1; i > pos; i--) board[i] = board[i-1];
      board[pos].vld   = 1'b1;
      board[pos].key   = k;
      board[pos].value = v;
    end
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FILTER_COEFF:   coeff = data[COEFF_W-1:0];
      CFG_PEAK_THRESHOLD: thr   = data[THR_W-1:0];
      CFG_PEAK_COUNT:     pcnt  = data[PCNT_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample through the filter and region tracker; a frame end queues the rank beats
  function automatic void track_sample(logic signed [SAMPLE_BITS-1:0] x,
                                       logic [KEY_BITS-1:0] k, logic first, logic last);
    logic signed [ACC_W-1:0] acc_before;
    longint                  prod;
    longint                  sum;
    longint                  step;
    longint                  thr_l;
    longint                  prev_l;
    int                      n;
    int                      i;
    rank_beat_t              beat;
    if (first) begin
      clear_board();
      region_live = 1'b0;
      acc         = ACC_W'(x);
      last_step   = DIFF_W'(x);
    end
    acc_before = acc;
    prod = longint'(acc_before) * longint'(coeff);
    sum  = longint'(x) + ((prod + 64'sd32768) >>> 16);
    if (sum > ACC_MAX) sum = ACC_MAX;
    else if (sum < ACC_MIN) sum = ACC_MIN;
    acc    = sum[ACC_W-1:0];
    step   = longint'(acc) - longint'(acc_before);
    thr_l  = longint'(thr);
    prev_l = longint'(last_step);

    if (prev_l < thr_l && step > thr_l) begin
      if (region_live) rank_insert(live_key, live_value);
      region_live = 1'b1;
      live_key    = k;
      live_value  = x;
    end else if (prev_l > thr_l && step < thr_l) begin
      if (region_live) rank_insert(live_key, live_value);
      region_live = 1'b0;
    end
    if (region_live && live_value < x) begin
      live_key   = k;
      live_value = x;
    end
    last_step = step[DIFF_W-1:0];

    if (last) begin
      n = int'(pcnt);
      if (n < 1) n = 1;
      if (n > MAX_PEAKS) n = MAX_PEAKS;
      if (region_live) rank_insert(live_key, live_value);
      region_live = 1'b0;
      for (i = 0; i < n; i++) begin
        beat.found = board[i].vld;
        beat.key   = board[i].vld ? board[i].key : '0;
        beat.value = board[i].vld ? board[i].value : '0;
        beat.rank  = i[RANK_W-1:0];
        beat.last  = (i == n - 1);
        ranks_due.push_back(beat);
      end
      clear_board();
    end
  endfunction

  always @(posedge clk) begin
    rank_beat_t got;
    rank_beat_t want;
    if (!rst_n) begin
      reset_detector();
      ranks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{found: out_peak_found, key: out_peak_key, value: out_peak_value,
                rank: out_peak_rank, last: out_last_result};
        if (ranks_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= REPORT_MAX)
            $display("%0t: rank beat with none due: found=%0b key=%h value=%0d rank=%0d last=%0b",
                     $realtime, got.found, got.key, got.value, got.rank, got.last);
        end else begin
          want = ranks_due.pop_front();
          if (got !== want) begin
            bad_beats++;
            if (bad_beats <= REPORT_MAX) begin
              $display("%0t: rank beat mismatch", $realtime);
              $display("  expected found=%0b key=%h value=%0d rank=%0d last=%0b",
                       want.found, want.key, want.value, want.rank, want.last);
              $display("  actual   found=%0b key=%h value=%0d rank=%0d last=%0b",
                       got.found, got.key, got.value, got.rank, got.last);
            end
          end
        end
      end
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        track_sample(in_sample_value, in_sample_key, in_first_of_frame, in_last_of_frame);
    end
    beats_pending  <= ranks_due.size();
    mismatch_count <= bad_beats;
  end

endmodule

### bench/dc_blocked_peak_detect_topk_test.sv
// Top of the peak detector bench: clock, reset, sample stimulus, register writes and verdict.
`timescale 1ns / 1ps
module dc_blocked_peak_detect_topk_test
  import dcpd_pkg::*;
();

  // cycles with no beat on either channel before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // idle cycles after the last due beat, covers the pipe of a sample with no result
  localparam int SETTLE_CYCLES = 12;

  // peak tops of the list-overflow frame: ties, extremes, one too many for the list
  localparam logic signed [SAMPLE_BITS-1:0] PEAK_TOPS [9] = '{
    16'sd100, 16'sh7FFF, 16'sd100, 16'sd5, 16'sh7FFF, 16'sh8001, 16'sd0, 16'sd100, 16'sd200
  };
  localparam int PLATEAU_LEVELS [4] = '{-32768, 0, 1000, 32767};

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_PULSE, SHAPE_PLATEAU} shape_t;

  logic                          clk;
  logic                          rst_n             = 1'b0;

  logic                          in_valid          = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_value   = '0;
  logic [KEY_BITS-1:0]           in_sample_key     = '0;
  logic                          in_first_of_frame = 1'b0;
  logic                          in_last_of_frame  = 1'b0;

  logic                          out_valid;
  logic                          out_stall         = 1'b0;
  logic                          out_peak_found;
  logic [KEY_BITS-1:0]           out_peak_key;
  logic signed [SAMPLE_BITS-1:0] out_peak_value;
  logic [RANK_W-1:0]             out_peak_rank;
  logic                          out_last_result;

  logic                          cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index         = CFG_FILTER_COEFF;
  logic [CFG_DATA_W-1:0]         cfg_data          = '0;

  int mismatch_count;
  int beats_pending;
  int send_idle_pct  = 0;   // chance per cycle that the sample source holds off
  int recv_stall_pct = 0;   // chance per cycle that the rank sink stalls
  int quiet_cycles   = 0;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  dc_blocked_peak_detect_topk dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .in_sample_key     (in_sample_key),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_found    (out_peak_found),
    .out_peak_key      (out_peak_key),
    .out_peak_value    (out_peak_value),
    .out_peak_rank     (out_peak_rank),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // watches both channels and the register port, predicts and compares
  dcpd_rank_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .in_sample_key     (in_sample_key),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_found    (out_peak_found),
    .out_peak_key      (out_peak_key),
    .out_peak_value    (out_peak_value),
    .out_peak_rank     (out_peak_rank),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .beats_pending     (beats_pending)
  );

  // rank sink back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // hang detection: any accepted beat on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One sample beat. Entered just after a rising edge; returns at the edge that takes it.
  // Gap cycles drop valid; a back-to-back beat keeps valid high with no glitch.
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x,
                             input logic [KEY_BITS-1:0] k,
                             input logic first, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_value   <= x;
    in_sample_key     <= k;
    in_first_of_frame <= first;
    in_last_of_frame  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Source pauses until every due rank beat is out, then lets the pipe empty.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All three registers, back to back; only called with the block idle.
  task automatic write_regs(input logic [COEFF_W-1:0] coeff, input logic [THR_W-1:0] thr,
                            input logic [PCNT_W-1:0] cnt);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILTER_COEFF;
    cfg_data  <= CFG_DATA_W'(coeff);
    @(negedge clk);
    cfg_index <= CFG_PEAK_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= CFG_PEAK_COUNT;
    cfg_data  <= CFG_DATA_W'(cnt);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(shape_t shape, int idx);
    int v;
    case (shape)
      SHAPE_WIDE:   v = int'($urandom_range(65535)) - 32768;
      SHAPE_NARROW: v = int'($urandom_range(400)) - 200;
      // alternating swings give a crossing nearly every sample
      SHAPE_PULSE:  v = (idx % 2) ? int'($urandom_range(32767)) : -int'($urandom_range(32768));
      // few levels, so equal maxima and equal peaks show up often
      default:      v = PLATEAU_LEVELS[$urandom_range(3)];
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Mostly whole frames with random content; about one draw in eight is a
  // loose sample with random frame marks (no start, double end, etc) instead.
  task automatic random_frames(input int n_items);
    int                  sent;
    int                  len;
    int                  i;
    int                  key_step;
    shape_t              shape;
    logic [KEY_BITS-1:0] k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        push_sample(shape_sample(SHAPE_WIDE, 0), $urandom,
                    $urandom_range(3) == 0, $urandom_range(3) == 0);
        sent++;
      end else begin
        len      = ($urandom_range(99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 24);
        shape    = shape_t'($urandom_range(3));
        k        = $urandom;
        key_step = $urandom_range(2);  // zero step repeats keys
        for (i = 0; i < len; i++) begin
          push_sample(shape_sample(shape, i), k, i == 0, i == len - 1);
          k = k + key_step;
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [COEFF_W-1:0] coeff, input logic [THR_W-1:0] thr,
                           input logic [PCNT_W-1:0] cnt, input int idle_pct,
                           input int stall_pct, input int n_items);
    settle_block();
    write_regs(coeff, thr, cnt);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    random_frames(n_items);
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: coefficient zero makes the filter step the plain sample delta.
    write_regs(16'd0, 32'd0, 4'd8);

    // Overflowing list: nine peaks for eight slots, ties, both sample extremes,
    // the last peak still open at frame end and pushing out the lowest entry.
    push_sample(-16'sd5, 32'd0, 1'b1, 1'b0);
    push_sample(-16'sd10, 32'd1, 1'b0, 1'b0);
    for (k = 0; k < 9; k++) begin
      push_sample(PEAK_TOPS[k], (k == 1) ? 32'hFFFF_FFFF : 32'd100 + k, 1'b0, k == 8);
      if (k < 8) push_sample(16'sh8000, 32'd200 + k, 1'b0, 1'b0);
    end

    // Rising crossing with a region already open: step goes up, flat, down with
    // no falling crossing (previous step sits on the threshold), then up again.
    // The flat sample repeats the maximum, so the earlier key must stay.
    push_sample(-16'sd100, 32'd10, 1'b1, 1'b0);
    push_sample(-16'sd150, 32'd11, 1'b0, 1'b0);
    push_sample(16'sd50, 32'd12, 1'b0, 1'b0);
    push_sample(16'sd50, 32'd13, 1'b0, 1'b0);
    push_sample(-16'sd50, 32'd14, 1'b0, 1'b0);
    push_sample(16'sd250, 32'd15, 1'b0, 1'b0);
    push_sample(-16'sd150, 32'd16, 1'b0, 1'b1);

    // Random part, one register setting per phase, idle pattern varies.
    run_phase(COEFF_RST, 32'd0, 4'd8, 0, 0, 30);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 4'd15, 83, 0, 30);
    run_phase(16'($urandom_range(65535)), 32'($urandom_range(6000)) - 32'd3000,
              4'd1, 0, 83, 30);
    // threshold extremes: nothing can cross, every rank comes back empty
    run_phase(16'd32768, 32'h7FFF_FFFF, 4'd0, 35, 35, 15);
    run_phase(16'($urandom_range(65535)), 32'h8000_0000, 4'd3, 0, 0, 15);
    run_phase(16'($urandom_range(65535)), 32'($urandom_range(2000)) - 32'd1000,
              4'($urandom_range(15)), 35, 35, 30);

    settle_block();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
